### rtl/chs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

    localparam int RANK_W = 4;
    localparam int SUIT_W = 2;

    // Rank sits above suit, so the packed value is the sort key.
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [SUIT_W-1:0] suit;
    } t_card;

endpackage

`default_nettype wire

### rtl/chs_card_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface chs_card_if;

    logic                        valid;
    logic                        ready;
    logic [chs_pkg::RANK_W-1:0]  card_rank;
    logic [chs_pkg::SUIT_W-1:0]  card_suit;
    logic                        last_card;

    modport source (output valid, output card_rank, output card_suit, output last_card,
                    input ready);
    modport sink   (input valid, input card_rank, input card_suit, input last_card,
                    output ready);

endinterface

`default_nettype wire

### rtl/chs_sorted_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface chs_sorted_if;

    logic                        valid;
    logic                        ready;
    logic [chs_pkg::RANK_W-1:0]  sorted_rank;
    logic [chs_pkg::SUIT_W-1:0]  sorted_suit;
    logic                        end_of_hand;
    logic                        overflowed;

    modport source (output valid, output sorted_rank, output sorted_suit,
                    output end_of_hand, output overflowed, input ready);
    modport sink   (input valid, input sorted_rank, input sorted_suit,
                    input end_of_hand, input overflowed, output ready);

endinterface

`default_nettype wire

### rtl/card_hand_sorter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Cards are taken one per cycle while a hand is collected; a card adds no result.
// After the last card (hand of n >= 2 stored cards) a sort pass runs, one compare per
// cycle through the one-read, one-write card memory; then one result per cycle while
// o_sorted.ready does not stall the output. A single card skips the sort pass.
// Synchronous active-low reset clears count, overflow flag, state and output valid;
// the card memory is not cleared and needs no clearing pass.
module card_hand_sorter_top #(
    parameter int MAX_CARDS = 8     // 2..64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    chs_card_if.sink    i_card,
    chs_sorted_if.source o_sorted
);
    import chs_pkg::*;

    localparam int AW = $clog2(MAX_CARDS);
    localparam int CW = $clog2(MAX_CARDS + 1);

    // sequencer codes
    localparam logic [2:0] S_COLLECT = 3'd0;   // taking cards
    localparam logic [2:0] S_RD_I    = 3'd1;   // read position i
    localparam logic [2:0] S_GET_I   = 3'd2;   // latch position i, read i+1
    localparam logic [2:0] S_CMP     = 3'd3;   // compare held card with position j
    localparam logic [2:0] S_WB      = 3'd4;   // write back position i
    localparam logic [2:0] S_E_RD    = 3'd5;   // read first sorted card
    localparam logic [2:0] S_E_LD    = 3'd6;   // move cards to the output register

    // hand memory, one write and one registered read per cycle
    t_card          r_mem [MAX_CARDS];
    t_card          r_rdata;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    t_card          mem_wd;
    logic [AW-1:0]  rd_addr;

    logic [2:0]     r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic           r_ovf, n_ovf;
    logic [AW-1:0]  r_last, n_last;    // index of last stored card
    logic [AW-1:0]  r_i, n_i;
    logic [AW-1:0]  r_j, n_j;
    logic [AW-1:0]  r_k, n_k;
    t_card          r_min, n_min;      // card currently held for position i

    // output register
    logic           r_out_valid, n_out_valid;
    t_card          r_out_card, n_out_card;
    logic           r_out_end, n_out_end;
    logic           r_out_ovf, n_out_ovf;

    logic           in_acc;
    logic           full;
    logic           out_free;
    logic           load_out;
    t_card          in_card;

    assign full     = (r_count == CW'(MAX_CARDS));
    assign in_acc   = i_card.valid && i_card.ready;
    assign out_free = !r_out_valid || o_sorted.ready;
    assign in_card  = '{rank: i_card.card_rank, suit: i_card.card_suit};

    assign i_card.ready         = (r_state == S_COLLECT);
    assign o_sorted.valid       = r_out_valid;
    assign o_sorted.sorted_rank = r_out_card.rank;
    assign o_sorted.sorted_suit = r_out_card.suit;
    assign o_sorted.end_of_hand = r_out_end;
    assign o_sorted.overflowed  = r_out_ovf;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_min       = r_min;
        n_out_valid = r_out_valid && !o_sorted.ready;
        n_out_card  = r_out_card;
        n_out_end   = r_out_end;
        n_out_ovf   = r_out_ovf;
        mem_we      = 1'b0;
        mem_wa      = r_count[AW-1:0];
        mem_wd      = in_card;
        rd_addr     = r_i;
        load_out    = 1'b0;

        unique case (r_state)
            S_COLLECT: begin
                if (in_acc) begin
                    if (!full) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_card.last_card) begin
                        n_last = full ? AW'(MAX_CARDS - 1) : r_count[AW-1:0];
                        n_i    = '0;
                        n_k    = '0;
                        // a single card needs no sort pass
                        if (!full && r_count == '0) begin
                            n_state = S_E_RD;
                        end else begin
                            n_state = S_RD_I;
                        end
                    end
                end
            end
            S_RD_I: begin
                rd_addr = r_i;
                n_state = S_GET_I;
            end
            S_GET_I: begin
                n_min   = r_rdata;
                n_j     = r_i + AW'(1);
                rd_addr = r_i + AW'(1);
                n_state = S_CMP;
            end
            S_CMP: begin
                // smaller later card takes position i, held card moves to j
                if (r_rdata < r_min) begin
                    mem_we = 1'b1;
                    mem_wa = r_j;
                    mem_wd = r_min;
                    n_min  = r_rdata;
                end
                if (r_j == r_last) begin
                    n_state = S_WB;
                end else begin
                    n_j     = r_j + AW'(1);
                    rd_addr = r_j + AW'(1);
                end
            end
            S_WB: begin
                mem_we = 1'b1;
                mem_wa = r_i;
                mem_wd = r_min;
                if (r_i + AW'(1) == r_last) begin
                    n_k     = '0;
                    n_state = S_E_RD;
                end else begin
                    n_i     = r_i + AW'(1);
                    rd_addr = r_i + AW'(1);
                    n_state = S_GET_I;
                end
            end
            S_E_RD: begin
                rd_addr = r_k;
                n_state = S_E_LD;
            end
            S_E_LD: begin
                rd_addr = r_k;
                if (out_free) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_card  = r_rdata;
                    n_out_end   = (r_k == r_last);
                    n_out_ovf   = r_ovf;
                    if (r_k == r_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_COLLECT;
                    end else begin
                        n_k     = r_k + AW'(1);
                        rd_addr = r_k + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_min      <= n_min;
        r_out_card <= n_out_card;
        r_out_end  <= n_out_end;
        r_out_ovf  <= n_out_ovf;
    end

    // count never runs past the store size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CARDS))
        else $error("card count beyond store size");

    // cards are dropped only once the store is full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> full)
        else $error("overflow flag set with room in store");

    // compare index always stays above position i
    a_cmp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_j > r_i))
        else $error("compare index not above position index");

    // loading the final card returns to collecting with an empty hand
    a_hand_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_k == r_last) |=> (r_state == S_COLLECT && r_count == '0 && !r_ovf
                                        && r_out_valid && r_out_end))
        else $error("hand not closed after last result");

endmodule

`default_nettype wire
